FILE: hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define ABPM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ABPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/abpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abpm_pkg: shared types, constants and float helpers
// Sample formats, register indexes, pipeline structs and the double/single
// conversion functions used by the peak meter.
// ----------------------------------------------------------------------------
package abpm_pkg;

	localparam int LANE_LIMIT       = 8;
	localparam int MAX_CHANNELS_DEF = 8;
	localparam int CHAN_W           = 3;
	localparam int COUNT_W          = 4;
	localparam int FMT_W            = 3;
	localparam int IDX_W            = 2;
	localparam int WDATA_W          = 32;

	localparam logic [FMT_W-1:0] FMT_S16 = 3'd0;
	localparam logic [FMT_W-1:0] FMT_S32 = 3'd1;
	localparam logic [FMT_W-1:0] FMT_F32 = 3'd2;
	localparam logic [FMT_W-1:0] FMT_F64 = 3'd3;

	localparam logic [IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
	localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

	// integer peaks are scaled down by these powers of two
	localparam logic [4:0] SHIFT_S16 = 5'd15;
	localparam logic [4:0] SHIFT_S32 = 5'd31;

	typedef struct packed {
		logic [FMT_W-1:0]   fmt;
		logic [CHAN_W-1:0]  ch;
		logic [COUNT_W-1:0] count;
		logic               sup;
		logic               last;
		logic [63:0]        block_time;
	} meta_t;

	typedef struct packed {
		logic               sign;
		logic [31:0]        mag;
		logic signed [9:0]  scale;
		logic [5:0]         lz;
		logic               zero;
		logic               inf;
		logic               nan;
		logic               pass;
		logic [63:0]        raw;
	} dec_t;

	typedef struct packed {
		logic [FMT_W-1:0]   fmt;
		logic [COUNT_W-1:0] count;
		logic               ok;
		logic [63:0]        block_time;
	} blk_ctl_t;

	typedef struct packed {
		logic [FMT_W-1:0]  fmt;
		logic [CHAN_W-1:0] ch;
		logic              last;
		logic              ok;
		logic [63:0]       block_time;
	} res_meta_t;

	// strict less-than on non-NaN doubles; zeros of either sign are equal
	function automatic logic dbl_lt(input logic [63:0] a, input logic [63:0] b);
		logic r;
		if (a[62:0] == 63'd0 && b[62:0] == 63'd0) r = 1'b0;
		else if (a[63] != b[63]) r = a[63];
		else if (!a[63]) r = a[62:0] < b[62:0];
		else r = a[62:0] > b[62:0];
		return r;
	endfunction

	// split a raw sample into sign, magnitude and binary scale; doubles pass through
	function automatic dec_t decode(input logic [63:0] raw, input logic [FMT_W-1:0] fmt);
		dec_t r;
		r = '0;
		r.raw = raw;
		if (fmt == FMT_S16) begin
			r.sign = raw[15];
			r.mag  = raw[15] ? (32'd0 - {16'hffff, raw[15:0]}) : {16'd0, raw[15:0]};
		end else if (fmt == FMT_S32) begin
			r.sign = raw[31];
			r.mag  = raw[31] ? (32'd0 - raw[31:0]) : raw[31:0];
		end else if (fmt == FMT_F32) begin
			r.sign = raw[31];
			if (raw[30:23] == 8'hff) begin
				r.inf = raw[22:0] == 23'd0;
				r.nan = raw[22:0] != 23'd0;
			end else if (raw[30:23] == 8'd0) begin
				r.mag   = {9'd0, raw[22:0]};
				r.scale = -10'sd149;
			end else begin
				r.mag   = {8'd0, 1'b1, raw[22:0]};
				r.scale = $signed({2'b00, raw[30:23]}) - 10'sd150;
			end
		end else begin
			r.pass = 1'b1;
		end
		r.zero = r.mag == 32'd0;
		for (int i = 0; i < 32; i++) begin
			if (r.mag[i]) r.lz = 6'(31 - i);
		end
		return r;
	endfunction

	// normalize a decoded sample into a double
	function automatic logic [63:0] build_double(input dec_t x);
		logic [63:0] d;
		logic [31:0] m;
		logic signed [11:0] ev;
		m  = x.mag << x.lz;
		ev = 12'(x.scale) + 12'sd1054 - $signed({6'd0, x.lz});
		if (x.pass) d = x.raw;
		else if (x.inf) d = {x.sign, 11'h7ff, 52'd0};
		else if (x.zero || x.nan) d = 64'd0;
		else d = {x.sign, ev[10:0], m[30:0], 21'd0};
		return d;
	endfunction

	// double to single, round to nearest even, overflow to infinity
	function automatic logic [31:0] dbl_to_single(input logic [63:0] d);
		logic               s;
		logic [10:0]        ex;
		logic signed [12:0] e;
		logic signed [12:0] shs;
		logic [5:0]         sh;
		logic [7:0]         ef;
		logic [116:0]       w;
		logic [23:0]        q;
		logic               rb;
		logic               st;
		logic [30:0]        body;
		logic [31:0]        r;
		s  = d[63];
		ex = d[62:52];
		e  = $signed({2'b00, ex}) - 13'sd1023;
		if (e >= -13'sd126) begin
			shs = 13'sd29;
			ef  = 8'(e + 13'sd127);
		end else begin
			shs = -e - 13'sd97;
			ef  = 8'd0;
		end
		sh   = (shs > 13'sd63) ? 6'd63 : 6'(shs);
		w    = {1'b1, d[51:0], 64'd0} >> sh;
		q    = w[87:64];
		rb   = w[63];
		st   = |w[62:0];
		body = {ef, q[22:0]} + {30'd0, rb & (st | q[0])};
		if (ex == 11'd0) r = {s, 31'd0};
		else if (ex == 11'h7ff || e > 13'sd127) r = {s, 8'hff, 23'd0};
		else r = {s, body};
		return r;
	endfunction

	// divide a single by 2^k, round to nearest even on underflow
	function automatic logic [31:0] single_scale(input logic [31:0] b, input logic [4:0] k);
		logic [7:0]  ex;
		logic [23:0] m;
		logic [5:0]  sh;
		logic [55:0] w;
		logic [23:0] q;
		logic        rb;
		logic        st;
		logic [30:0] body;
		logic [31:0] r;
		ex   = b[30:23];
		m    = (ex == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
		sh   = (ex == 8'd0) ? {1'b0, k} : ({1'b0, k} + 6'd1 - 6'(ex));
		w    = {m, 32'd0} >> sh;
		q    = w[55:32];
		rb   = w[31];
		st   = |w[30:0];
		body = {8'd0, q[22:0]} + {30'd0, rb & (st | q[0])};
		if (k == 5'd0 || ex == 8'hff || b[30:0] == 31'd0) r = b;
		else if (ex > {3'd0, k}) r = {b[31], ex - {3'd0, k}, b[22:0]};
		else r = {b[31], body};
		return r;
	endfunction

endpackage

FILE: hdl/abpm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abpm_if: channel interfaces of the peak meter
// Sample input channel, peak result channel and register write channel.
// ----------------------------------------------------------------------------
interface abpm_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] sample_bits;
	logic        last_in_block;
	logic signed [63:0] timestamp;
	modport source(output valid, sample_bits, last_in_block, timestamp, input ready);
	modport sink(input valid, sample_bits, last_in_block, timestamp, output ready);
endinterface

interface abpm_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  channel_index;
	logic [31:0] min_peak;
	logic [31:0] max_peak;
	logic signed [63:0] block_time;
	logic        peaks_valid;
	logic        last_of_block;
	modport source(output valid, channel_index, min_peak, max_peak, block_time,
		peaks_valid, last_of_block, input ready);
	modport sink(input valid, channel_index, min_peak, max_peak, block_time,
		peaks_valid, last_of_block, output ready);
endinterface

interface abpm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [31:0] wr_data;
	modport source(output valid, reg_index, wr_data, input ready);
	modport sink(input valid, reg_index, wr_data, output ready);
endinterface

FILE: hdl/abpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abpm_front: sample intake and per-channel peak update
// Holds the registers, deals samples to channels, converts them to double
// over two stages and updates the min/max stores; hands finished blocks on.
// ----------------------------------------------------------------------------
module abpm_front #(
	parameter int MAX_CHANNELS = abpm_pkg::MAX_CHANNELS_DEF,
	parameter int LANES = (MAX_CHANNELS < abpm_pkg::LANE_LIMIT) ? MAX_CHANNELS
		: abpm_pkg::LANE_LIMIT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	abpm_in_if.sink                samples,
	abpm_cfg_if.sink               cfg,
	input  logic                   full,
	output logic                   push,
	output abpm_pkg::blk_ctl_t     push_ctl,
	output logic [LANES-1:0][63:0] push_min,
	output logic [LANES-1:0][63:0] push_max
);
	import abpm_pkg::*;

	localparam int CH_W = (LANES > 1) ? $clog2(LANES) : 1;

	logic [FMT_W-1:0]   fmt_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [CH_W-1:0]    pos_q;
	logic [COUNT_W-1:0] n_act;
	logic [CH_W-1:0]    pos_eff;
	logic [COUNT_W-1:0] pos_inc;
	logic               adv;
	logic               take;

	logic        v_s1, v_s2, v_s3;
	meta_t       meta_s1, meta_s2, meta_s3;
	logic [63:0] raw_s1;
	dec_t        dec_s2;
	logic [63:0] d_s3;
	logic        nan_s3;

	logic [LANES-1:0][63:0] min_q, max_q;
	logic [CH_W-1:0] ch_idx;
	logic            upd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_S16;
			cnt_q <= 4'd2;
		end else if (cfg.valid) begin
			if (cfg.reg_index == REG_SAMPLE_FORMAT) fmt_q <= cfg.wr_data[FMT_W-1:0];
			if (cfg.reg_index == REG_CHANNEL_COUNT) cnt_q <= cfg.wr_data[COUNT_W-1:0];
		end
	end

	// clamp count to 1..LANES, restart position past the count
	assign n_act   = (cnt_q == '0) ? 4'd1 : ((cnt_q > 4'(LANES)) ? 4'(LANES) : cnt_q);
	assign pos_eff = ({{(COUNT_W-CH_W){1'b0}}, pos_q} >= n_act) ? '0 : pos_q;
	assign pos_inc = {{(COUNT_W-CH_W){1'b0}}, pos_eff} + 4'd1;

	assign adv           = !(v_s3 && meta_s3.last && full);
	assign samples.ready = adv;
	assign take          = samples.valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			if (samples.last_in_block) pos_q <= '0;
			else if (!fmt_q[2]) pos_q <= (pos_inc >= n_act) ? '0 : pos_inc[CH_W-1:0];
			else pos_q <= pos_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s1             <= samples.sample_bits;
			meta_s1.fmt        <= fmt_q;
			meta_s1.ch         <= 3'(pos_eff);
			meta_s1.count      <= n_act;
			meta_s1.sup        <= !fmt_q[2];
			meta_s1.last       <= samples.last_in_block;
			meta_s1.block_time <= samples.timestamp;
			dec_s2             <= decode(raw_s1, meta_s1.fmt);
			meta_s2            <= meta_s1;
			d_s3               <= build_double(dec_s2);
			nan_s3             <= dec_s2.pass ? (dec_s2.raw[62:52] == 11'h7ff
				&& dec_s2.raw[51:0] != 52'd0) : dec_s2.nan;
			meta_s3            <= meta_s2;
		end
	end

	// read-modify-write of one channel's peaks
	assign ch_idx = meta_s3.ch[CH_W-1:0];
	assign upd    = meta_s3.sup && !nan_s3;

	always_comb begin
		push_min = min_q;
		push_max = max_q;
		if (upd && dbl_lt(d_s3, min_q[ch_idx])) push_min[ch_idx] = d_s3;
		if (upd && dbl_lt(max_q[ch_idx], d_s3)) push_max[ch_idx] = d_s3;
	end

	assign push                = adv && v_s3 && meta_s3.last;
	assign push_ctl.fmt        = meta_s3.fmt;
	assign push_ctl.count      = meta_s3.sup ? meta_s3.count : 4'd1;
	assign push_ctl.ok         = meta_s3.sup;
	assign push_ctl.block_time = meta_s3.block_time;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '0;
		end else if (adv && v_s3) begin
			if (meta_s3.last) begin
				min_q <= '0;
				max_q <= '0;
			end else begin
				min_q <= push_min;
				max_q <= push_max;
			end
		end
	end

endmodule

FILE: hdl/abpm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abpm_back: block queue and result drain
// Holds one finished block, reads one channel a cycle unless stalled and
// converts peaks to single precision in two stages into the output register.
// ----------------------------------------------------------------------------
module abpm_back #(
	parameter int MAX_CHANNELS = abpm_pkg::MAX_CHANNELS_DEF,
	parameter int LANES = (MAX_CHANNELS < abpm_pkg::LANE_LIMIT) ? MAX_CHANNELS
		: abpm_pkg::LANE_LIMIT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  abpm_pkg::blk_ctl_t     push_ctl,
	input  logic [LANES-1:0][63:0] push_min,
	input  logic [LANES-1:0][63:0] push_max,
	output logic                   full,
	abpm_out_if.source             peaks
);
	import abpm_pkg::*;

	localparam int CH_W = (LANES > 1) ? $clog2(LANES) : 1;

	logic [LANES-1:0][63:0] bank_min_q, bank_max_q;
	blk_ctl_t               ctl_q;
	logic                   full_q;
	logic [CH_W-1:0]        idx_q;
	logic                   last_rd;
	logic                   rd;
	logic                   en1, en2, en3;
	logic [4:0]             k_b2;

	logic        v_b1, v_b2, v_b3;
	res_meta_t   meta_b1, meta_b2, meta_b3;
	logic [63:0] dmin_b1, dmax_b1;
	logic [31:0] fmin_b2, fmax_b2;
	logic [31:0] smin_b3, smax_b3;

	assign en3     = !v_b3 || peaks.ready;
	assign en2     = !v_b2 || en3;
	assign en1     = !v_b1 || en2;
	assign rd      = full_q && en1;
	assign last_rd = ({{(COUNT_W-CH_W){1'b0}}, idx_q} + 4'd1) == ctl_q.count;
	assign full    = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= '0;
		end else if (push) begin
			full_q <= 1'b1;
			idx_q  <= '0;
		end else if (rd) begin
			if (last_rd) full_q <= 1'b0;
			idx_q <= last_rd ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			bank_min_q <= push_min;
			bank_max_q <= push_max;
			ctl_q      <= push_ctl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
		end else begin
			if (en1) v_b1 <= rd;
			if (en2) v_b2 <= v_b1;
			if (en3) v_b3 <= v_b2;
		end
	end

	always_comb begin
		unique case (meta_b2.fmt)
			FMT_S16: k_b2 = SHIFT_S16;
			FMT_S32: k_b2 = SHIFT_S32;
			default: k_b2 = 5'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			dmin_b1            <= bank_min_q[idx_q];
			dmax_b1            <= bank_max_q[idx_q];
			meta_b1.fmt        <= ctl_q.fmt;
			meta_b1.ch         <= 3'(idx_q);
			meta_b1.last       <= last_rd;
			meta_b1.ok         <= ctl_q.ok;
			meta_b1.block_time <= ctl_q.block_time;
		end
		if (en2) begin
			fmin_b2 <= dbl_to_single(dmin_b1);
			fmax_b2 <= dbl_to_single(dmax_b1);
			meta_b2 <= meta_b1;
		end
		if (en3) begin
			smin_b3 <= meta_b2.ok ? single_scale(fmin_b2, k_b2) : 32'd0;
			smax_b3 <= meta_b2.ok ? single_scale(fmax_b2, k_b2) : 32'd0;
			meta_b3 <= meta_b2;
		end
	end

	assign peaks.valid         = v_b3;
	assign peaks.channel_index = meta_b3.ch;
	assign peaks.min_peak      = smin_b3;
	assign peaks.max_peak      = smax_b3;
	assign peaks.block_time    = meta_b3.block_time;
	assign peaks.peaks_valid   = meta_b3.ok;
	assign peaks.last_of_block = meta_b3.last;

endmodule

FILE: hdl/audio_block_peak_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_block_peak_meter_unit: per-channel min/max meter for audio blocks
// Tracks signed 16/32-bit and float 32/64-bit interleaved samples and
// reports each channel's peaks as single-precision values at block end.
// ----------------------------------------------------------------------------
// The unit takes one sample item per clock unless stalled and deals
// samples to channels 0..n-1 in turn, n = channel_count clamped to
// 1..LANES. A sample is captured, decoded and converted to double, then
// updates its channel's min/max store in a single read-modify-write, so
// samples for the same channel may follow each other in consecutive
// cycles. On the sample flagged last_in_block the stores are copied into
// a one-entry block queue and cleared, so the next block starts at once.
// The back end drains it at one result item per cycle unless the output
// stalls (n results, or one invalid result for an unsupported format).
// A second block end that arrives while the queue still holds the
// previous block stalls the input until the queue's last result has been
// read out. Registers are written through cfg, which is always ready.
// ----------------------------------------------------------------------------
module audio_block_peak_meter_unit #(
	parameter int MAX_CHANNELS = abpm_pkg::MAX_CHANNELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	abpm_in_if.sink    samples,
	abpm_cfg_if.sink   cfg,
	abpm_out_if.source peaks
);
	import abpm_pkg::*;

	// result lanes never exceed the per-block result limit
	localparam int LANES = (MAX_CHANNELS < LANE_LIMIT) ? MAX_CHANNELS : LANE_LIMIT;

	logic                   full;
	logic                   push;
	blk_ctl_t               push_ctl;
	logic [LANES-1:0][63:0] push_min;
	logic [LANES-1:0][63:0] push_max;

	// front: intake, channel dealing, double conversion, peak update
	abpm_front #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.LANES(LANES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.cfg(cfg),
		.full(full),
		.push(push),
		.push_ctl(push_ctl),
		.push_min(push_min),
		.push_max(push_max)
	);

	// back: block queue, single conversion and result register
	abpm_back #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.LANES(LANES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_ctl(push_ctl),
		.push_min(push_min),
		.push_max(push_max),
		.full(full),
		.peaks(peaks)
	);

endmodule

FILE: hdl/abpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abpm_checker: port-level checks for the peak meter
// Watches the result channel over time and binds to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abpm_checker (
	input logic        clk,
	input logic        arst_n,
	abpm_out_if.source peaks
);

	`ABPM_ASSERT(a_hold_valid, clk, arst_n, peaks.valid && !peaks.ready |=> peaks.valid, "result dropped while stalled")
	`ABPM_ASSERT(a_hold_data, clk, arst_n, peaks.valid && !peaks.ready |=> $stable(peaks.min_peak) && $stable(peaks.max_peak) && $stable(peaks.channel_index), "result changed while stalled")
	`ABPM_ASSERT(a_invalid_form, clk, arst_n, peaks.valid && !peaks.peaks_valid |-> peaks.last_of_block && peaks.channel_index == 3'd0 && peaks.min_peak == 32'd0 && peaks.max_peak == 32'd0, "bad invalid result")
	`ABPM_ASSERT(a_top_lane_last, clk, arst_n, peaks.valid && peaks.channel_index == 3'd7 |-> peaks.last_of_block, "top channel not last")
	`ABPM_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !peaks.valid, "result right after reset")

endmodule

bind audio_block_peak_meter_unit abpm_checker u_abpm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.peaks(peaks)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the audio block peak meter
// Feeds interleaved sample items in random bursts across all sample formats
// and channel counts, predicts each block's per-channel min/max pairs in
// single precision, and checks every result item against that prediction.
// ----------------------------------------------------------------------------
module tb;
	import abpm_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 30;

	typedef enum logic [1:0] {OP_SAMPLE, OP_WRITE, OP_SETTLE} op_kind_e;

	typedef struct {
		op_kind_e    kind;
		logic [63:0] bits;
		logic        last;
		logic [63:0] stamp;
		logic [1:0]  idx;
		logic [31:0] data;
	} stim_op_t;

	typedef struct {
		logic [2:0]  ch;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [63:0] stamp;
		logic        ok;
		logic        last;
	} peak_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	abpm_in_if  s_if ();
	abpm_cfg_if c_if ();
	abpm_out_if p_if ();

	audio_block_peak_meter_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(s_if),
		.cfg    (c_if),
		.peaks  (p_if)
	);

	always #4 clk = ~clk;

	// pending stimulus and expected peak pairs
	stim_op_t   stim_q[$];
	peak_pair_t pair_q[$];

	// predictor copy of the block's registers and stores
	logic [2:0] pm_format = FMT_S16;
	logic [3:0] pm_count  = 4'd2;
	int         pm_pos    = 0;
	real        pm_min[8];
	real        pm_max[8];

	int errors = 0;
	int n_samples = 0;
	int n_pairs = 0;
	int n_blocks = 0;
	int quiet = 0;
	int idle_cycles = 0;
	bit stim_done = 1'b0;

	initial begin
		for (int i = 0; i < 8; i++) begin
			pm_min[i] = 0.0;
			pm_max[i] = 0.0;
		end
	end

	function automatic int active_lanes();
		int n;
		n = pm_count;
		if (n == 0) n = 1;
		if (n > 8) n = 8;
		return n;
	endfunction

	// double to single, round to nearest even, overflow to infinity
	function automatic logic [31:0] to_single(input logic [63:0] d);
		int           e;
		int           sh;
		logic [7:0]   ef;
		logic [116:0] w;
		logic [52:0]  q;
		logic         rb;
		logic         st;
		logic [30:0]  body;
		e = int'(d[62:52]) - 1023;
		if (d[62:52] == 11'd0) return {d[63], 31'd0};
		if (d[62:52] == 11'h7ff || e > 127) return {d[63], 8'hff, 23'd0};
		if (e >= -126) begin
			sh = 29;
			ef = 8'(e + 127);
		end else begin
			sh = 29 + (-126 - e);
			ef = 8'd0;
			if (sh > 60) sh = 60;
		end
		w    = {1'b1, d[51:0], 64'd0} >> sh;
		q    = w[116:64];
		rb   = w[63];
		st   = |w[62:0];
		body = {ef, q[22:0]} + {30'd0, rb & (st | q[0])};
		return {d[63], body};
	endfunction

	// raw sample to exact value; flags NaN
	function automatic real sample_value(input logic [63:0] raw, input logic [2:0] fmt,
			output bit is_nan);
		real         v;
		logic [23:0] mag;
		int          sc;
		is_nan = 1'b0;
		v = 0.0;
		if (fmt == FMT_S16) v = real'($signed(raw[15:0]));
		else if (fmt == FMT_S32) v = real'($signed(raw[31:0]));
		else if (fmt == FMT_F32) begin
			if (raw[30:23] == 8'hff) begin
				if (raw[22:0] != 23'd0) is_nan = 1'b1;
				else v = $bitstoreal({raw[31], 11'h7ff, 52'd0});
			end else begin
				mag = (raw[30:23] == 8'd0) ? {1'b0, raw[22:0]} : {1'b1, raw[22:0]};
				sc  = (raw[30:23] == 8'd0) ? -149 : int'(raw[30:23]) - 150;
				v   = real'(mag) * (2.0 ** sc);
				if (raw[31]) v = -v;
			end
		end else begin
			if (raw[62:52] == 11'h7ff && raw[51:0] != 52'd0) is_nan = 1'b1;
			else v = $bitstoreal(raw);
		end
		return v;
	endfunction

	// stored peak to result bits; integer peaks drop by 2^15 or 2^31
	function automatic logic [31:0] peak_bits(input real v, input logic [2:0] fmt);
		logic [31:0] b;
		b = to_single($realtobits(v));
		if (b[30:0] != 31'd0) begin
			if (fmt == FMT_S16) b[30:23] = b[30:23] - 8'd15;
			else if (fmt == FMT_S32) b[30:23] = b[30:23] - 8'd31;
		end
		return b;
	endfunction

	task automatic track_sample(input stim_op_t op);
		int         n;
		bit         nan;
		real        v;
		peak_pair_t pp;
		n = active_lanes();
		if (pm_pos >= n) pm_pos = 0;
		if (pm_format <= FMT_F64) begin
			v = sample_value(op.bits, pm_format, nan);
			if (!nan) begin
				if (v < pm_min[pm_pos]) pm_min[pm_pos] = v;
				if (v > pm_max[pm_pos]) pm_max[pm_pos] = v;
			end
			pm_pos = (pm_pos + 1 >= n) ? 0 : pm_pos + 1;
		end
		if (op.last) begin
			n_blocks++;
			if (pm_format > FMT_F64) begin
				pp = '{3'd0, 32'd0, 32'd0, op.stamp, 1'b0, 1'b1};
				pair_q.push_back(pp);
			end else begin
				for (int c = 0; c < n; c++) begin
					pp.ch    = 3'(c);
					pp.lo    = peak_bits(pm_min[c], pm_format);
					pp.hi    = peak_bits(pm_max[c], pm_format);
					pp.stamp = op.stamp;
					pp.ok    = 1'b1;
					pp.last  = (c + 1 == n);
					pair_q.push_back(pp);
				end
			end
			for (int c = 0; c < 8; c++) begin
				pm_min[c] = 0.0;
				pm_max[c] = 0.0;
			end
			pm_pos = 0;
		end
	endtask

	// ---------------- driver ----------------
	// Hold valid until the item is taken; between items the sender runs
	// in bursts with random gaps. Settle ops wait for the block to drain.
	bit busy = 1'b0;
	bit busy_cfg = 1'b0;
	stim_op_t cur;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		logic sv;
		logic cv;
		if (!arst_n) begin
			s_if.valid <= 1'b0;
			s_if.sample_bits <= '0;
			s_if.last_in_block <= 1'b0;
			s_if.timestamp <= '0;
			c_if.valid <= 1'b0;
			c_if.reg_index <= '0;
			c_if.wr_data <= '0;
			busy = 1'b0;
		end else begin
			sv = s_if.valid;
			cv = c_if.valid;
			// retire accepted items into the predictor
			if (busy && !busy_cfg && s_if.valid && s_if.ready) begin
				track_sample(cur);
				n_samples++;
				busy = 1'b0;
				sv = 1'b0;
			end
			if (busy && busy_cfg && c_if.valid && c_if.ready) begin
				if (cur.idx == REG_SAMPLE_FORMAT) pm_format = cur.data[2:0];
				else if (cur.idx == REG_CHANNEL_COUNT) pm_count = cur.data[3:0];
				busy = 1'b0;
				cv = 1'b0;
			end
			if (!busy && stim_q.size() > 0) begin
				case (stim_q[0].kind)
					OP_SAMPLE: begin
						if (gap_left > 0) gap_left--;
						else begin
							cur = stim_q.pop_front();
							busy = 1'b1;
							busy_cfg = 1'b0;
							sv = 1'b1;
							s_if.sample_bits <= cur.bits;
							s_if.last_in_block <= cur.last;
							s_if.timestamp <= cur.stamp;
							if (burst_left > 0) burst_left--;
							else begin
								burst_left = $urandom_range(0, 12);
								gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
							end
						end
					end
					OP_WRITE: begin
						cur = stim_q.pop_front();
						busy = 1'b1;
						busy_cfg = 1'b1;
						cv = 1'b1;
						c_if.reg_index <= cur.idx;
						c_if.wr_data <= cur.data;
					end
					default: begin
						// drain: nothing owed and the pipeline quiet
						if (pair_q.size() == 0 && quiet >= SETTLE_CYCLES) void'(stim_q.pop_front());
					end
				endcase
			end
			s_if.valid <= sv;
			c_if.valid <= cv;
		end
	end

	// ---------------- monitor ----------------
	// Receiver stalls follow a mode that is redrawn at random when mode_cnt wraps.
	int stall_mode = 0;
	int mode_cnt = 0;

	always @(posedge clk or negedge arst_n) begin
		peak_pair_t exp_pair;
		logic       rdy;
		if (!arst_n) begin
			p_if.ready <= 1'b0;
		end else begin
			if (p_if.valid && p_if.ready) begin
				n_pairs++;
				if (pair_q.size() == 0) begin
					$error("unexpected peak item: channel %0d", p_if.channel_index);
					errors++;
				end else begin
					exp_pair = pair_q.pop_front();
					if (p_if.channel_index !== exp_pair.ch) begin
						$error("channel_index: expected %0d, actual %0d", exp_pair.ch,
							p_if.channel_index);
						errors++;
					end
					if (p_if.min_peak !== exp_pair.lo) begin
						$error("min_peak: expected %h, actual %h", exp_pair.lo, p_if.min_peak);
						errors++;
					end
					if (p_if.max_peak !== exp_pair.hi) begin
						$error("max_peak: expected %h, actual %h", exp_pair.hi, p_if.max_peak);
						errors++;
					end
					if (p_if.block_time !== exp_pair.stamp) begin
						$error("block_time: expected %h, actual %h", exp_pair.stamp,
							p_if.block_time);
						errors++;
					end
					if (p_if.peaks_valid !== exp_pair.ok) begin
						$error("peaks_valid: expected %0d, actual %0d", exp_pair.ok,
							p_if.peaks_valid);
						errors++;
					end
					if (p_if.last_of_block !== exp_pair.last) begin
						$error("last_of_block: expected %0d, actual %0d", exp_pair.last,
							p_if.last_of_block);
						errors++;
					end
				end
			end
			if (++mode_cnt >= 64) begin
				mode_cnt = 0;
				stall_mode = $urandom_range(0, 3);
			end
			case (stall_mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = (mode_cnt % 4) == 0;
				default: rdy = $urandom_range(0, 7) != 0;
			endcase
			p_if.ready <= rdy;
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_if.valid && s_if.ready) || (p_if.valid && p_if.ready)
					|| (c_if.valid && c_if.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if ((s_if.valid && s_if.ready) || (p_if.valid && p_if.ready)) quiet <= 0;
			else quiet <= quiet + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ---------------- stimulus ----------------
	task automatic add_sample(input logic [63:0] bits, input logic last);
		stim_op_t op;
		op = '{OP_SAMPLE, bits, last, {$urandom, $urandom}, 2'd0, 32'd0};
		stim_q.push_back(op);
	endtask

	task automatic add_write(input logic [1:0] idx, input logic [31:0] data);
		stim_op_t op;
		op = '{OP_WRITE, 64'd0, 1'b0, 64'd0, idx, data};
		stim_q.push_back(op);
	endtask

	task automatic add_settle();
		stim_op_t op;
		op = '{OP_SETTLE, 64'd0, 1'b0, 64'd0, 2'd0, 32'd0};
		stim_q.push_back(op);
	endtask

	task automatic reconfigure(input logic [2:0] fmt, input logic [3:0] cnt);
		add_settle();
		add_write(REG_SAMPLE_FORMAT, {$urandom} & 32'hffff_fff8 | 32'(fmt));
		add_write(REG_CHANNEL_COUNT, {$urandom} & 32'hffff_fff0 | 32'(cnt));
	endtask

	// random sample with a bias toward the format's corner values
	function automatic logic [63:0] rand_sample(input logic [2:0] fmt);
		logic [63:0] r;
		r = {$urandom, $urandom};
		if ($urandom_range(0, 3) != 0) return r;
		case (fmt)
			FMT_S16: r[15:0] = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
			FMT_S32: r[31:0] = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
			FMT_F32: case ($urandom_range(0, 4))
				0: r[31:0] = 32'h7fc0_0001;
				1: r[31:0] = {r[31], 8'hff, 23'd0};
				2: r[31:0] = 32'h8000_0000;
				3: r[30:23] = 8'd0;
				default: r[30:23] = 8'hfe;
			endcase
			default: case ($urandom_range(0, 5))
				0: r = {r[63], 11'h7ff, 52'd1 | r[51:0]};
				1: r = {r[63], 63'h47ef_ffff_f000_0000};
				2: r = {r[63], 63'h47ef_ffff_efff_ffff};
				3: r[62:52] = 11'd0;
				4: r[62:52] = 11'd874 + 11'($urandom_range(0, 25));
				default: r = 64'h8000_0000_0000_0000;
			endcase
		endcase
		return r;
	endfunction

	initial begin
		int n;
		int len;
		logic [2:0] fmt;
		logic [3:0] cnt;

		// directed: reset settings, signed 16 extremes on two channels
		add_sample(64'hffff_ffff_ffff_8000, 1'b0);
		add_sample(64'h0000_0000_0000_7fff, 1'b0);
		add_sample(64'h0000_0000_0000_0001, 1'b1);
		// signed 32 extremes, block ending mid-frame on three channels
		reconfigure(FMT_S32, 4'd3);
		add_sample(64'h0000_0000_8000_0000, 1'b0);
		add_sample(64'hffff_ffff_7fff_ffff, 1'b0);
		add_sample(64'h0000_0000_ffff_ffff, 1'b0);
		add_sample(64'h0000_0000_0000_0005, 1'b1);
		// float32: NaN, negative zero, both infinities, a subnormal
		reconfigure(FMT_F32, 4'd4);
		add_sample(64'h0000_0000_7fc0_0000, 1'b0);
		add_sample(64'h0000_0000_8000_0000, 1'b0);
		add_sample(64'h0000_0000_7f80_0000, 1'b0);
		add_sample(64'h0000_0000_ff80_0000, 1'b0);
		add_sample(64'h0000_0000_8000_0001, 1'b1);
		// float64 past single range, channel count zero acts as one lane
		reconfigure(FMT_F64, 4'd0);
		add_sample(64'h47ef_ffff_f000_0000, 1'b0);
		add_sample(64'hc7ef_ffff_f000_0000, 1'b0);
		add_sample(64'h7ff0_0000_0000_0001, 1'b1);
		// channel count above the limit saturates to eight
		reconfigure(FMT_S16, 4'd15);
		for (int i = 0; i < 9; i++) add_sample(rand_sample(FMT_S16), i == 8);
		// position beyond count: shrink the count in the middle of a block
		reconfigure(FMT_S16, 4'd4);
		for (int i = 0; i < 3; i++) add_sample(rand_sample(FMT_S16), 1'b0);
		reconfigure(FMT_S16, 4'd2);
		add_sample(64'h0000_0000_0000_1234, 1'b1);
		// unsupported format ignores samples and reports one invalid item
		reconfigure(3'd4, 4'd3);
		add_sample(64'h0000_0000_0000_7fff, 1'b0);
		add_sample(64'h0000_0000_0000_8000, 1'b1);

		// random phases over all settings
		n = 0;
		while (n < 360) begin
			fmt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
			cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
			reconfigure(fmt, cnt);
			for (int b = 0; b < $urandom_range(1, 4); b++) begin
				len = (cnt == 0 ? 1 : (cnt > 8 ? 8 : int'(cnt))) * $urandom_range(1, 3);
				if ($urandom_range(0, 4) == 0) len = $urandom_range(1, len);
				for (int i = 0; i < len; i++) begin
					add_sample(rand_sample(fmt), i == len - 1);
					n++;
				end
			end
		end
		add_settle();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (stim_q.size() == 0 && !busy);
		wait (pair_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d sample items in %0d blocks, %0d peak items checked",
			n_samples, n_blocks, n_pairs);
		$display("formats s16/s32/f32/f64/unsupported, channel counts 0..15");
		if (errors == 0 && pair_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/abpm_pkg.sv
hdl/abpm_if.sv
hdl/abpm_front.sv
hdl/abpm_back.sv
hdl/audio_block_peak_meter_unit.sv
hdl/abpm_checker.sv
tb/tb.sv
